@@ rtl/b2b_pkg.sv @@
// Shared types, constants and helpers for the BLAKE2b hash engine.
`timescale 1ns / 1ps
`default_nettype none
package b2b_pkg;

	typedef logic [63:0] word_t;

	localparam int unsigned CFG_W = 64;
	localparam int unsigned IDX_W = 3;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_DIGEST   = 3'd0;
	localparam logic [IDX_W-1:0] REG_KEY      = 3'd1;
	localparam logic [IDX_W-1:0] REG_SALT_LO  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SALT_HI  = 3'd3;
	localparam logic [IDX_W-1:0] REG_PERS_LO  = 3'd4;
	localparam logic [IDX_W-1:0] REG_PERS_HI  = 3'd5;

	localparam word_t IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

	localparam logic [3:0] SIGMA [10][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}};

	// Work-vector indexes a, b, c, d of the eight mixes of one round
	localparam logic [3:0] MIX_IDX [8][4] = '{
		'{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd1, 4'd5, 4'd9, 4'd13},
		'{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15},
		'{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
		'{4'd2, 4'd7, 4'd8, 4'd13}, '{4'd3, 4'd4, 4'd9, 4'd14}};

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       start;      // load chaining value and clear counters
		logic       absorb;     // store the input word into the block
		logic       inc_ctr;    // add 128 to the byte counter
		logic       init_v;     // load the work vector
		logic       final_blk;  // this compression is the final one
		logic       mix;        // run one half of a mix step
		logic       fold;       // fold work vector into chaining value
		logic       pad;        // zero the unfilled block tail
	} b2b_cmd_t;

	typedef struct packed {
		logic       block_full; // sixteen words buffered
		logic       mix_done;   // the last half step of the last round is running
	} b2b_sts_t;

	function automatic word_t ror64(input word_t x, input int unsigned n);
		ror64 = (x >> n) | (x << (64 - n));
	endfunction

	// Keep the low n bytes of a word, n from 0 to 8
	function automatic word_t byte_mask(input word_t x, input logic [3:0] n);
		word_t m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n) m[i*8 +: 8] = 8'hff;
		end
		byte_mask = x & m;
	endfunction

endpackage
`default_nettype wire

@@ rtl/b2b_datapath.sv @@
// BLAKE2b datapath: block buffer, byte counter, chaining value and a shared mix unit.
`timescale 1ns / 1ps
`default_nettype none
module b2b_datapath #(
	parameter int unsigned ROUNDS = 12
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire b2b_pkg::b2b_cmd_t cmd,
	output b2b_pkg::b2b_sts_t    sts,
	input  wire logic [63:0]     in_word,
	input  wire logic [3:0]      in_bytes,
	input  wire logic            in_last,
	input  wire logic [6:0]      digest_len,
	input  wire logic [6:0]      key_len,
	input  wire logic [63:0]     salt_lo,
	input  wire logic [63:0]     salt_hi,
	input  wire logic [63:0]     pers_lo,
	input  wire logic [63:0]     pers_hi,
	input  wire logic [2:0]      rd_sel,
	output logic [63:0]          rd_word
);
	localparam int unsigned RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

	b2b_pkg::word_t h_q [8];
	b2b_pkg::word_t m_q [16];
	b2b_pkg::word_t v_q [16];
	logic [127:0]   ctr_q;
	logic [4:0]     fill_q;
	logic [RND_W-1:0] rnd_q;
	logic [3:0]     sig_q;
	logic [2:0]     step_q;
	logic           phase_q;
	logic [3:0]     tail_bytes_q;

	logic [63:0]  p0;
	logic [127:0] t_final;
	logic [3:0]   ia, ib, ic, id;
	b2b_pkg::word_t a1, d1, c1, b1, mx;

	// Parameter block word zero
	assign p0 = {32'd0, 8'd1, 8'd1, 1'b0, key_len, 1'b0, digest_len};

	// Final count: compressed bytes plus the buffered ones
	assign t_final = ctr_q + 128'(tail_bytes_q) +
		((fill_q == 5'd0) ? 128'd0 : 128'({fill_q - 5'd1, 3'b000}));

	// One half of a mix step: first half takes the even message word and
	// rotates by 32 and 24, second half the odd word and rotates by 16 and 63
	assign ia = b2b_pkg::MIX_IDX[step_q][0];
	assign ib = b2b_pkg::MIX_IDX[step_q][1];
	assign ic = b2b_pkg::MIX_IDX[step_q][2];
	assign id = b2b_pkg::MIX_IDX[step_q][3];
	assign mx = m_q[b2b_pkg::SIGMA[sig_q][{step_q, phase_q}]];
	assign a1 = v_q[ia] + v_q[ib] + mx;
	assign d1 = phase_q ? b2b_pkg::ror64(v_q[id] ^ a1, 16) : b2b_pkg::ror64(v_q[id] ^ a1, 32);
	assign c1 = v_q[ic] + d1;
	assign b1 = phase_q ? b2b_pkg::ror64(v_q[ib] ^ c1, 63) : b2b_pkg::ror64(v_q[ib] ^ c1, 24);

	assign sts.block_full = (fill_q == 5'd16);
	assign sts.mix_done   = phase_q && (step_q == 3'd7) && (32'(rnd_q) == ROUNDS - 1);
	assign rd_word = h_q[rd_sel];

	// Control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			rnd_q   <= '0;
			sig_q   <= '0;
			step_q  <= '0;
			phase_q <= 1'b0;
			ctr_q   <= '0;
			tail_bytes_q <= '0;
		end else begin
			if (cmd.start) begin
				ctr_q <= '0;
			end else if (cmd.inc_ctr) begin
				ctr_q <= ctr_q + 128'd128;
			end
			// Count stored words; a non-last word always carries eight bytes
			if (cmd.absorb) begin
				fill_q <= (cmd.start ? 5'd0 : fill_q) + 5'd1;
				tail_bytes_q <= in_last ? in_bytes : 4'd8;
			end else if (cmd.start || cmd.inc_ctr || cmd.fold) begin
				fill_q <= '0;
				if (cmd.start) tail_bytes_q <= '0;
			end
			// Advance half step, step, round and schedule row
			if (cmd.init_v) begin
				rnd_q   <= '0;
				sig_q   <= '0;
				step_q  <= '0;
				phase_q <= 1'b0;
			end else if (cmd.mix) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						rnd_q <= rnd_q + RND_W'(1);
						sig_q <= (sig_q == 4'd9) ? 4'd0 : sig_q + 4'd1;
					end
				end
			end
		end
	end

	// Block buffer, chaining value and work vector
	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			m_q[fill_q[3:0]] <= in_last ? b2b_pkg::byte_mask(in_word, in_bytes) : in_word;
		end
		// Zero the tail past the word stored in this cycle
		if (cmd.pad) begin
			for (int i = 0; i < 16; i++) begin
				if (5'(i) > fill_q || (5'(i) == fill_q && !cmd.absorb)) m_q[i] <= '0;
			end
		end
		if (cmd.start) begin
			h_q[0] <= b2b_pkg::IV[0] ^ p0;
			h_q[1] <= b2b_pkg::IV[1];
			h_q[2] <= b2b_pkg::IV[2];
			h_q[3] <= b2b_pkg::IV[3];
			h_q[4] <= b2b_pkg::IV[4] ^ salt_lo;
			h_q[5] <= b2b_pkg::IV[5] ^ salt_hi;
			h_q[6] <= b2b_pkg::IV[6] ^ pers_lo;
			h_q[7] <= b2b_pkg::IV[7] ^ pers_hi;
		end else if (cmd.fold) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
		end
		if (cmd.init_v) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			for (int i = 8; i < 12; i++) v_q[i] <= b2b_pkg::IV[i-8];
			v_q[12] <= b2b_pkg::IV[4] ^ (cmd.final_blk ? t_final[63:0] : ctr_q[63:0]);
			v_q[13] <= b2b_pkg::IV[5] ^ (cmd.final_blk ? t_final[127:64] : ctr_q[127:64]);
			v_q[14] <= cmd.final_blk ? ~b2b_pkg::IV[6] : b2b_pkg::IV[6];
			v_q[15] <= b2b_pkg::IV[7];
		end else if (cmd.mix) begin
			v_q[ia] <= a1;
			v_q[ib] <= b1;
			v_q[ic] <= c1;
			v_q[id] <= d1;
		end
	end

	// Assertions
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= 5'd16)
		else $error("block fill overran");
	a_rnd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rnd_q) < ROUNDS || !cmd.mix) else $error("mix past last round");
	a_no_absorb_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.absorb |-> fill_q < 5'd16) else $error("absorb into full block");
endmodule
`default_nettype wire

@@ rtl/b2b_ctrl.sv @@
// BLAKE2b controller: sequences absorb, compression and digest output.
`timescale 1ns / 1ps
`default_nettype none
module b2b_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [3:0]      in_bytes,
	input  wire logic            in_last,
	input  wire logic [6:0]      dig_len,
	output b2b_pkg::b2b_cmd_t    cmd,
	input  wire b2b_pkg::b2b_sts_t sts,
	output logic [2:0]           rd_sel,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [3:0]           out_bytes,
	output logic                 out_last
);
	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_MIX, S_FOLD, S_OUT
	} state_t;

	state_t     state_q;
	logic       open_q, final_q;
	logic [6:0] left_q;
	logic [3:0] clip_bytes;
	logic       need_cmp;
	logic       accept;

	assign clip_bytes = (in_bytes > 4'd8) ? 4'd8 : in_bytes;
	// Hold the item off while the full block ahead of it is compressed
	assign need_cmp = in_valid && open_q && sts.block_full &&
		(!in_last || clip_bytes != 4'd0);
	assign in_ready = (state_q == S_IDLE) && !need_cmp;
	assign accept = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);
	assign out_bytes = (left_q >= 7'd8) ? 4'd8 : left_q[3:0];
	assign out_last  = (left_q <= 7'd8);

	// Datapath commands
	always_comb begin
		cmd = '0;
		cmd.start     = accept && !open_q;
		// Store the word unless the last item carries nothing
		cmd.absorb    = accept && (!in_last || clip_bytes != 4'd0);
		cmd.pad       = accept && in_last;
		cmd.inc_ctr   = (state_q == S_IDLE) && need_cmp;
		cmd.init_v    = (state_q == S_INIT);
		cmd.final_blk = final_q;
		cmd.mix       = (state_q == S_MIX);
		cmd.fold      = (state_q == S_FOLD);
	end

	// Controller state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q  <= 1'b0;
			final_q <= 1'b0;
			left_q  <= '0;
			rd_sel  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						open_q <= 1'b1;
						if (in_last) begin
							final_q <= 1'b1;
							state_q <= S_INIT;
						end
					end else if (need_cmp) begin
						final_q <= 1'b0;
						state_q <= S_INIT;
					end
				end
				S_INIT: state_q <= S_MIX;
				S_MIX: if (sts.mix_done) state_q <= S_FOLD;
				S_FOLD: begin
					if (final_q) begin
						state_q <= S_OUT;
						rd_sel  <= '0;
						left_q  <= (dig_len == 7'd0) ? 7'd1 :
							((dig_len > 7'd64) ? 7'd64 : dig_len);
						open_q  <= 1'b0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						rd_sel <= rd_sel + 3'd1;
						left_q <= left_q - 7'd8;
						if (out_last) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Assertions
	a_out_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FOLD && final_q))
		else $error("digest without final compression");
	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("input taken while busy");
	a_out_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_bytes != 4'd0)) else $error("empty digest word");
endmodule
`default_nettype wire

@@ rtl/blake2b_hash_engine.sv @@
// BLAKE2b hash engine top level: configuration registers and stream ports.
// Usage:
//   Input stream s_axis carries message words, eight little-endian bytes each;
//   tuser holds the byte count (meaningful on the last item), tlast ends the
//   message. The first item of a message loads the chaining value from the
//   configuration registers, sampled at that moment.
//   Output stream m_axis gives ceil(digest/8) digest words, tlast on the last.
// Sequence:
//   An item is taken when offered in idle, unless a full block is buffered
//   ahead of it. Such an item (other than a last item with no bytes) is held
//   off while the block is compressed: a counter update, a setup state, the
//   half-mix steps on the shared mix unit (two per mix step) and a fold; it
//   is taken after the fold, once per 16 items. The last item starts the
//   final compression; the first digest word is offered once the fold is
//   done, then the words leave one per cycle while the receiver takes them.
// Reset: clears controller state and the configuration registers but the
//   digest length, which returns to 64; no message is open.
// Stall: a held output word keeps its value; no new item enters until the
//   whole digest has been taken.
`timescale 1ns / 1ps
`default_nettype none
module blake2b_hash_engine #(
	parameter int unsigned ROUNDS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // data_word
	input  wire logic [3:0]  s_axis_tuser,   // valid_bytes
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // digest_word
	output logic [3:0]       m_axis_tuser,   // digest_valid_bytes
	output logic             m_axis_tlast
);
	logic [6:0]  digest_q, key_q;
	logic [63:0] salt_lo_q, salt_hi_q, pers_lo_q, pers_hi_q;
	logic [6:0]  key_clip;
	b2b_pkg::b2b_cmd_t cmd;
	b2b_pkg::b2b_sts_t sts;
	logic [2:0]  rd_sel;
	logic [63:0] rd_word;
	logic [6:0]  dig_clip;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_q  <= 7'd64;
			key_q     <= '0;
			salt_lo_q <= '0;
			salt_hi_q <= '0;
			pers_lo_q <= '0;
			pers_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				b2b_pkg::REG_DIGEST:  digest_q  <= cfg_data[6:0];
				b2b_pkg::REG_KEY:     key_q     <= cfg_data[6:0];
				b2b_pkg::REG_SALT_LO: salt_lo_q <= cfg_data;
				b2b_pkg::REG_SALT_HI: salt_hi_q <= cfg_data;
				b2b_pkg::REG_PERS_LO: pers_lo_q <= cfg_data;
				b2b_pkg::REG_PERS_HI: pers_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key_clip = (key_q > 7'd64) ? 7'd64 : key_q;
	assign dig_clip = (digest_q == 7'd0) ? 7'd1 : ((digest_q > 7'd64) ? 7'd64 : digest_q);

	b2b_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_bytes(s_axis_tuser), .in_last(s_axis_tlast),
		.dig_len(digest_q), .cmd(cmd), .sts(sts), .rd_sel(rd_sel),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_bytes(m_axis_tuser), .out_last(m_axis_tlast)
	);

	b2b_datapath #(.ROUNDS(ROUNDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_word(s_axis_tdata),
		.in_bytes((s_axis_tuser > 4'd8) ? 4'd8 : s_axis_tuser),
		.in_last(s_axis_tlast),
		.digest_len(dig_clip), .key_len(key_clip),
		.salt_lo(salt_lo_q), .salt_hi(salt_hi_q),
		.pers_lo(pers_lo_q), .pers_hi(pers_hi_q),
		.rd_sel(rd_sel), .rd_word(rd_word)
	);

	assign m_axis_tdata = b2b_pkg::byte_mask(rd_word, m_axis_tuser);
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the BLAKE2b hash engine over its stream ports.
`timescale 1ns / 1ps
module tb;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  nbytes;
		logic        last;
	} msg_item_t;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
	} digest_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [3:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	blake2b_hash_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// Predictor copy of configuration and engine state
	logic [6:0]  digest_len_reg, key_len_reg;
	logic [63:0] salt_reg [2];
	logic [63:0] pers_reg [2];
	logic [63:0] chain_h [8];
	logic [63:0] msg_blk [16];
	logic [63:0] cnt_lo, cnt_hi;
	int unsigned fill_words;
	logic        in_message;

	msg_item_t    pending_items[$];
	digest_item_t expected_digest[$];
	int unsigned  errors, words_seen, msgs_sent;
	int unsigned  send_idle_pct, recv_stall_pct;
	logic         hold_off;

	always #10 clk = ~clk;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Run one compression of msg_blk into chain_h
	function automatic void compress(input logic [63:0] tlo, input logic [63:0] thi,
			input logic last_blk);
		logic [63:0] v [16];
		logic [3:0] s [16];
		int a, b, c, d;
		for (int i = 0; i < 8; i++) begin
			v[i] = chain_h[i];
			v[i+8] = b2b_pkg::IV[i];
		end
		v[12] ^= tlo;
		v[13] ^= thi;
		if (last_blk) v[14] = ~v[14];
		for (int r = 0; r < 12; r++) begin
			for (int j = 0; j < 16; j++) s[j] = b2b_pkg::SIGMA[r % 10][j];
			for (int g = 0; g < 8; g++) begin
				a = b2b_pkg::MIX_IDX[g][0]; b = b2b_pkg::MIX_IDX[g][1];
				c = b2b_pkg::MIX_IDX[g][2]; d = b2b_pkg::MIX_IDX[g][3];
				v[a] = v[a] + v[b] + msg_blk[s[2*g]];
				v[d] = v[d] ^ v[a]; v[d] = {v[d][31:0], v[d][63:32]};
				v[c] = v[c] + v[d];
				v[b] = v[b] ^ v[c]; v[b] = {v[b][23:0], v[b][63:24]};
				v[a] = v[a] + v[b] + msg_blk[s[2*g+1]];
				v[d] = v[d] ^ v[a]; v[d] = {v[d][15:0], v[d][63:16]};
				v[c] = v[c] + v[d];
				v[b] = v[b] ^ v[c]; v[b] = {v[b][62:0], v[b][63]};
			end
		end
		for (int i = 0; i < 8; i++) chain_h[i] ^= v[i] ^ v[i+8];
	endfunction

	function automatic int unsigned digest_len();
		if (digest_len_reg == 0) return 1;
		if (digest_len_reg > 64) return 64;
		return digest_len_reg;
	endfunction

	// Absorb one accepted item; queue digest words on the last one
	function automatic void hash_absorb(input msg_item_t it);
		logic [63:0] w, p0, tlo, prev, m;
		int unsigned nb, klen, dl, left, n;
		w = it.data;
		nb = (it.nbytes > 8) ? 8 : it.nbytes;
		if (!in_message) begin
			klen = (key_len_reg > 64) ? 64 : key_len_reg;
			p0 = 64'(digest_len()) | (64'(klen) << 8) | (64'd1 << 16) | (64'd1 << 24);
			chain_h[0] = b2b_pkg::IV[0] ^ p0;
			for (int i = 1; i < 4; i++) chain_h[i] = b2b_pkg::IV[i];
			chain_h[4] = b2b_pkg::IV[4] ^ salt_reg[0];
			chain_h[5] = b2b_pkg::IV[5] ^ salt_reg[1];
			chain_h[6] = b2b_pkg::IV[6] ^ pers_reg[0];
			chain_h[7] = b2b_pkg::IV[7] ^ pers_reg[1];
			cnt_lo = 0; cnt_hi = 0; fill_words = 0; in_message = 1;
		end
		if (!it.last || nb > 0) begin
			if (fill_words >= 16) begin
				prev = cnt_lo;
				cnt_lo += 128;
				if (cnt_lo < prev) cnt_hi++;
				compress(cnt_lo, cnt_hi, 0);
				fill_words = 0;
			end
			if (it.last && nb < 8) w &= (64'd1 << (8*nb)) - 1;
			msg_blk[fill_words] = w;
			fill_words++;
		end
		if (!it.last) return;
		tlo = cnt_lo;
		prev = tlo;
		if (nb > 0) tlo += 64'((fill_words - 1) * 8 + nb);
		else tlo += 64'(fill_words * 8);
		for (int i = fill_words; i < 16; i++) msg_blk[i] = 0;
		compress(tlo, cnt_hi + ((tlo < prev) ? 64'd1 : 64'd0), 1);
		dl = digest_len();
		for (int i = 0; i < (dl + 7) / 8; i++) begin
			left = dl - 8*i;
			n = (left >= 8) ? 8 : left;
			m = (n < 8) ? ((64'd1 << (8*n)) - 1) : '1;
			expected_digest.push_back('{chain_h[i] & m, 4'(n), 1'(i + 1 == (dl + 7) / 8)});
		end
		in_message = 0;
		fill_words = 0;
	endfunction

	// Driver: present queued items, idling at random
	always @(posedge clk) begin
		if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				msg_item_t it;
				it = pending_items.pop_front();
				s_axis_tvalid <= 1;
				s_axis_tdata <= it.data;
				s_axis_tuser <= it.nbytes;
				s_axis_tlast <= it.last;
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	// Predict on every accepted item
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			hash_absorb('{s_axis_tdata, s_axis_tuser, s_axis_tlast});
	end

	// Monitor: check digest words and stall the receiver at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_seen++;
			if (expected_digest.size() == 0) begin
				report("unexpected word", m_axis_tdata, 0);
			end else begin
				digest_item_t e;
				e = expected_digest.pop_front();
				if (m_axis_tdata !== e.word) report("digest_word", m_axis_tdata, e.word);
				if (m_axis_tuser !== e.nbytes) report("valid_bytes", m_axis_tuser, e.nbytes);
				if (m_axis_tlast !== e.last) report("last_word", m_axis_tlast, e.last);
			end
		end
		m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			b2b_pkg::REG_DIGEST:  digest_len_reg = val[6:0];
			b2b_pkg::REG_KEY:     key_len_reg = val[6:0];
			b2b_pkg::REG_SALT_LO: salt_reg[0] = val;
			b2b_pkg::REG_SALT_HI: salt_reg[1] = val;
			b2b_pkg::REG_PERS_LO: pers_reg[0] = val;
			b2b_pkg::REG_PERS_HI: pers_reg[1] = val;
			default: ;
		endcase
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Queue one message of full words plus a last item of nb bytes
	task automatic queue_msg(input int unsigned full_words, input logic [3:0] nb,
			input logic [3:0] mid_nb);
		for (int i = 0; i < full_words; i++)
			pending_items.push_back('{rand64(), mid_nb, 1'b0});
		pending_items.push_back('{rand64(), nb, 1'b1});
		msgs_sent++;
	endtask

	// Wait for the queue and engine to drain
	task automatic drain();
		while (pending_items.size() > 0 || s_axis_tvalid || expected_digest.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic random_cfg();
		write_reg(b2b_pkg::REG_DIGEST, 64'($urandom_range(127)));
		write_reg(b2b_pkg::REG_KEY, 64'($urandom_range(127)));
		write_reg(b2b_pkg::REG_SALT_LO, rand64());
		write_reg(b2b_pkg::REG_SALT_HI, rand64());
		write_reg(b2b_pkg::REG_PERS_LO, rand64());
		write_reg(b2b_pkg::REG_PERS_HI, rand64());
	endtask

	initial begin
		int phase_idle [4] = '{0, 77, 0, 26};
		int phase_stall [4] = '{0, 0, 77, 26};
		int unsigned budget;
		clk = 0; arst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0; s_axis_tlast = 0;
		m_axis_tready = 0; hold_off = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		errors = 0; words_seen = 0; msgs_sent = 0;
		digest_len_reg = 64; key_len_reg = 0;
		salt_reg = '{0, 0}; pers_reg = '{0, 0};
		in_message = 0; fill_words = 0; cnt_lo = 0; cnt_hi = 0;
		for (int i = 0; i < 16; i++) msg_blk[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: defaults, empty message, short last items, odd sizes, clipped settings
		queue_msg(0, 4'd0, 4'd8);
		queue_msg(0, 4'd3, 4'd8);
		queue_msg(1, 4'd15, 4'd2);
		queue_msg(15, 4'd8, 4'd8);
		drain();
		write_reg(b2b_pkg::REG_DIGEST, 64'd0);
		write_reg(b2b_pkg::REG_KEY, 64'd127);
		write_reg(b2b_pkg::REG_SALT_LO, '1);
		write_reg(b2b_pkg::REG_SALT_HI, '1);
		write_reg(b2b_pkg::REG_PERS_LO, '1);
		write_reg(b2b_pkg::REG_PERS_HI, '1);
		queue_msg(0, 4'd8, 4'd8);
		drain();
		write_reg(b2b_pkg::REG_DIGEST, 64'd100);
		write_reg(b2b_pkg::REG_KEY, 64'd64);
		pending_items.push_back('{64'hffffffffffffffff, 4'd8, 1'b0});
		queue_msg(0, 4'd1, 4'd8);
		drain();

		// Random phases with differing idling, several settings
		budget = 0;
		for (int ph = 0; ph < 4; ph++) begin
			random_cfg();
			send_idle_pct = phase_idle[ph];
			recv_stall_pct = phase_stall[ph];
			if (ph == 0) begin
				// Long receiver hold-off while the sender keeps offering items
				fork
					begin
						hold_off = 1;
						repeat (400) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int m = 0; m < 3; m++) begin
				int unsigned fw;
				fw = ($urandom_range(5) == 0) ? $urandom_range(17, 33) : $urandom_range(0, 9);
				queue_msg(fw, 4'($urandom_range(15)), 4'($urandom_range(15)));
				budget += fw + 1;
			end
			if (ph == 0) begin
				queue_msg(2, 4'd5, 4'd8);
				queue_msg(2, 4'd8, 4'd8);
			end
			drain();
		end

		$display("Covered %0d messages, %0d digest words checked, %0d budgeted random items.",
			msgs_sent, words_seen, budget);
		if (errors == 0) $display("tb passed");
		else $display("tb failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("tb failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/b2b_pkg.sv
rtl/b2b_datapath.sv
rtl/b2b_ctrl.sv
rtl/blake2b_hash_engine.sv
dv/tb.sv
